// File: src/ifs_pkg.sv
// Shared types, codes and constants of the IPP frame scanner.
package ifs_pkg;

   localparam int MAX_GROUPS    = 16;
   localparam int HEADER_LEN    = 9;
   localparam int RECORD_MIN    = 5;
   localparam int LEN_BYTES     = 2;
   localparam int END_TAG       = 8'h03;
   localparam int MAX_DELIM_TAG = 8'h0f;

   typedef enum logic [3:0] {
      PH_HEADER = 4'd0,
      PH_TAG    = 4'd1,
      PH_NL_HI  = 4'd2,
      PH_NL_LO  = 4'd3,
      PH_NAME   = 4'd4,
      PH_VL_HI  = 4'd5,
      PH_VL_LO  = 4'd6,
      PH_VALUE  = 4'd7,
      PH_DATA   = 4'd8,
      PH_WAIT   = 4'd9,
      PH_IGNORE = 4'd10
   } phase_type;

   typedef enum logic [3:0] {
      CL_HEADER    = 4'd0,
      CL_GROUP_TAG = 4'd1,
      CL_END_TAG   = 4'd2,
      CL_VALUE_TAG = 4'd3,
      CL_NAME_LEN  = 4'd4,
      CL_NAME      = 4'd5,
      CL_VALUE_LEN = 4'd6,
      CL_VALUE     = 4'd7,
      CL_DATA      = 4'd8,
      CL_IGNORED   = 4'd9
   } class_type;

   localparam logic [3:0] ERR_NONE          = 4'd0;
   localparam logic [3:0] ERR_SHORT_HEADER  = 4'd1;
   localparam logic [3:0] ERR_MAJOR_NEG     = 4'd2;
   localparam logic [3:0] ERR_MINOR_NEG     = 4'd3;
   localparam logic [3:0] ERR_OPID_NEG      = 4'd4;
   localparam logic [3:0] ERR_REQID_NEG     = 4'd5;
   localparam logic [3:0] ERR_DELIM_EXP     = 4'd6;
   localparam logic [3:0] ERR_GROUPS        = 4'd7;
   localparam logic [3:0] ERR_END_AT_DELIM  = 4'd8;
   localparam logic [3:0] ERR_RECORD_SHORT  = 4'd9;
   localparam logic [3:0] ERR_VTAG_NEG      = 4'd10;
   localparam logic [3:0] ERR_NLEN_NEG      = 4'd11;
   localparam logic [3:0] ERR_NAME_TRUNC    = 4'd12;
   localparam logic [3:0] ERR_VLEN_NEG      = 4'd13;
   localparam logic [3:0] ERR_VALUE_TRUNC   = 4'd14;

endpackage

// File: src/ipp_frame_scanner.sv
// Top level of the IPP frame scanner: byte pipeline and scan state machine.

// The scanner takes one frame byte per cycle and returns one classified result per byte,
// so a stream runs at one transaction per clock when the result side does not stall.
// Each byte is captured in an input register and goes through the phase update against
// the scan state into a result register that drives rsp_valid; a stalled result holds
// the byte in the input register. The rate is set by the phase update, which also carries
// the frame state from one byte to the next. A byte with req_is_last ends the frame and
// the next byte starts a new one. fault_code reports the first error on the byte where
// it becomes final; later bytes of that frame are class ignored and repeat the code.
module ipp_frame_scanner
   import ifs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_frame_byte,
   input  logic       req_is_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [3:0] rsp_byte_class,
   output logic [4:0] rsp_group_number,
   output logic [3:0] rsp_fault_code,
   output logic       rsp_frame_done,
   output logic       rsp_frame_good
);

   // pipeline registers
   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       out_vld_ff, out_vld_in;
   logic [3:0] out_class_ff;
   logic [4:0] out_group_ff;
   logic [3:0] out_err_ff;
   logic       out_done_ff, out_good_ff;

   // scan state
   phase_type   phase_ff, phase_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [15:0] pend_ff, pend_in;
   logic [4:0]  groups_ff, groups_in;
   logic [3:0]  held_ff, held_in;
   logic        latched_ff, latched_in;

   logic        out_adv, step;

   // shared decode
   logic [7:0]  b;
   logic        last;
   logic [3:0]  cnt_bump;
   logic [15:0] pend_or, pend_dec;
   logic [3:0]  trunc_code;
   logic        tag_act, fail_hit;
   logic [3:0]  fail_code;
   logic        is_end_tag, is_delim;

   class_type   cls;
   logic [3:0]  err;
   logic        good;

   assign out_adv   = !out_vld_ff || !rsp_stall;
   assign step      = in_vld_ff && out_adv;
   assign req_stall = in_vld_ff && !out_adv;
   assign in_vld_in = req_stall ? in_vld_ff : req_valid;
   assign out_vld_in = out_adv ? in_vld_ff : out_vld_ff;

   assign b    = in_byte_ff;
   assign last = in_last_ff;

   always_comb begin
      cnt_bump   = (cnt_ff == 4'hf) ? cnt_ff : cnt_ff + 4'd1;
      pend_or    = pend_ff | {8'h00, b};
      pend_dec   = (pend_ff != 16'd0) ? pend_ff - 16'd1 : pend_ff;
      trunc_code = (cnt_bump >= 4'(RECORD_MIN - 1)) ? ERR_NAME_TRUNC : ERR_RECORD_SHORT;
      is_end_tag = (b == 8'(END_TAG));
      is_delim   = (b <= 8'(MAX_DELIM_TAG));
   end

   // failure decode, shared by next state and outputs
   always_comb begin
      fail_hit  = 1'b0;
      fail_code = ERR_NONE;
      tag_act   = 1'b0;
      case (phase_ff)
         PH_HEADER: begin
            if (cnt_ff < 4'(HEADER_LEN - 1)) begin
               if (last) begin
                  fail_hit  = 1'b1;
                  fail_code = ERR_SHORT_HEADER;
               end
            end else if (held_ff != ERR_NONE) begin
               fail_hit  = 1'b1;
               fail_code = held_ff;
            end else if (!is_delim) begin
               fail_hit  = 1'b1;
               fail_code = ERR_DELIM_EXP;
            end else begin
               tag_act = 1'b1;
            end
         end
         PH_TAG: tag_act = 1'b1;
         PH_NL_HI, PH_NL_LO, PH_NAME, PH_VL_HI: begin
            if (last) begin
               fail_hit  = 1'b1;
               fail_code = trunc_code;
            end
         end
         PH_VL_LO: begin
            if (last) begin
               fail_hit  = 1'b1;
               fail_code = (pend_or != 16'd0) ? ERR_VALUE_TRUNC : ERR_END_AT_DELIM;
            end
         end
         PH_VALUE: begin
            if (last) begin
               fail_hit  = 1'b1;
               fail_code = (pend_dec != 16'd0) ? ERR_VALUE_TRUNC : ERR_END_AT_DELIM;
            end
         end
         PH_WAIT: begin
            if (pend_dec == 16'd0) begin
               fail_hit  = 1'b1;
               fail_code = held_ff;
            end else if (last) begin
               fail_hit  = 1'b1;
               fail_code = ERR_RECORD_SHORT;
            end
         end
         default: ;
      endcase
      if (tag_act && !is_end_tag) begin
         if (is_delim) begin
            if (groups_ff >= 5'(MAX_GROUPS)) begin
               fail_hit  = 1'b1;
               fail_code = ERR_GROUPS;
            end else if (last) begin
               fail_hit  = 1'b1;
               fail_code = ERR_END_AT_DELIM;
            end
         end else if (last) begin
            fail_hit  = 1'b1;
            fail_code = ERR_RECORD_SHORT;
         end
      end
   end

   // next state, before the end-of-frame clear
   always_comb begin
      phase_in   = phase_ff;
      cnt_in     = cnt_ff;
      pend_in    = pend_ff;
      groups_in  = groups_ff;
      held_in    = held_ff;
      latched_in = latched_ff;
      case (phase_ff)
         PH_HEADER: begin
            if (cnt_ff < 4'(HEADER_LEN - 1) && !last) begin
               if (held_ff == ERR_NONE && b[7]) begin
                  case (cnt_ff)
                     4'd0:    held_in = ERR_MAJOR_NEG;
                     4'd1:    held_in = ERR_MINOR_NEG;
                     4'd2:    held_in = ERR_OPID_NEG;
                     4'd4:    held_in = ERR_REQID_NEG;
                     default: held_in = held_ff;
                  endcase
               end
               cnt_in = cnt_ff + 4'd1;
            end
         end
         PH_NL_HI: begin
            cnt_in = cnt_bump;
            if (!last) begin
               if (b[7]) begin
                  held_in  = ERR_NLEN_NEG;
                  pend_in  = 16'(RECORD_MIN - 1) - {12'd0, cnt_bump};
                  phase_in = PH_WAIT;
               end else begin
                  pend_in  = {b, 8'h00};
                  phase_in = PH_NL_LO;
               end
            end
         end
         PH_NL_LO: begin
            cnt_in  = cnt_bump;
            pend_in = pend_or;
            if (!last) phase_in = (pend_or != 16'd0) ? PH_NAME : PH_VL_HI;
         end
         PH_NAME: begin
            cnt_in  = cnt_bump;
            pend_in = pend_dec;
            if (!last && pend_dec == 16'd0) phase_in = PH_VL_HI;
         end
         PH_VL_HI: begin
            cnt_in = cnt_bump;
            if (!last) begin
               if (b[7]) begin
                  held_in  = ERR_VLEN_NEG;
                  pend_in  = 16'(LEN_BYTES - 1);
                  phase_in = PH_WAIT;
               end else begin
                  pend_in  = {b, 8'h00};
                  phase_in = PH_VL_LO;
               end
            end
         end
         PH_VL_LO: begin
            cnt_in  = cnt_bump;
            pend_in = pend_or;
            if (!last) phase_in = (pend_or != 16'd0) ? PH_VALUE : PH_TAG;
         end
         PH_VALUE: begin
            pend_in = pend_dec;
            if (!last && pend_dec == 16'd0) phase_in = PH_TAG;
         end
         PH_WAIT: pend_in = pend_dec;
         default: ;
      endcase
      if (tag_act) begin
         if (is_end_tag) begin
            if (!last) phase_in = PH_DATA;
         end else if (is_delim) begin
            if (groups_ff < 5'(MAX_GROUPS)) begin
               groups_in = groups_ff + 5'd1;
               if (!last) phase_in = PH_TAG;
            end
         end else begin
            cnt_in = 4'd0;
            if (!last) begin
               if (b[7]) begin
                  held_in  = ERR_VTAG_NEG;
                  pend_in  = 16'(RECORD_MIN - 1);
                  phase_in = PH_WAIT;
               end else begin
                  phase_in = PH_NL_HI;
               end
            end
         end
      end
      if (fail_hit) begin
         held_in    = fail_code;
         latched_in = 1'b1;
         phase_in   = PH_IGNORE;
      end
   end

   // result fields
   always_comb begin
      cls  = CL_IGNORED;
      err  = fail_hit ? fail_code : ERR_NONE;
      good = 1'b0;
      case (phase_ff)
         PH_HEADER: cls = CL_HEADER;
         PH_NL_HI, PH_NL_LO: cls = CL_NAME_LEN;
         PH_NAME:   cls = CL_NAME;
         PH_VL_HI, PH_VL_LO: cls = CL_VALUE_LEN;
         PH_VALUE:  cls = CL_VALUE;
         PH_DATA: begin
            cls  = CL_DATA;
            good = last;
         end
         PH_WAIT:   cls = CL_IGNORED;
         PH_TAG:    cls = CL_IGNORED;
         default: begin
            cls = CL_IGNORED;
            err = latched_ff ? held_ff : ERR_NONE;
         end
      endcase
      if (tag_act) begin
         if (is_end_tag) begin
            cls  = CL_END_TAG;
            good = last;
         end else if (is_delim) begin
            cls = CL_GROUP_TAG;
         end else begin
            cls = CL_VALUE_TAG;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         phase_ff   <= PH_HEADER;
         cnt_ff     <= 4'd0;
         pend_ff    <= 16'd0;
         groups_ff  <= 5'd0;
         held_ff    <= ERR_NONE;
         latched_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         if (step) begin
            if (last) begin
               phase_ff   <= PH_HEADER;
               cnt_ff     <= 4'd0;
               pend_ff    <= 16'd0;
               groups_ff  <= 5'd0;
               held_ff    <= ERR_NONE;
               latched_ff <= 1'b0;
            end else begin
               phase_ff   <= phase_in;
               cnt_ff     <= cnt_in;
               pend_ff    <= pend_in;
               groups_ff  <= groups_in;
               held_ff    <= held_in;
               latched_ff <= latched_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_byte_ff <= req_frame_byte;
         in_last_ff <= req_is_last;
      end
      if (step) begin
         out_class_ff <= cls;
         out_group_ff <= groups_in;
         out_err_ff   <= err;
         out_done_ff  <= fail_hit || good;
         out_good_ff  <= good;
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_byte_class   = out_class_ff;
   assign rsp_group_number = out_group_ff;
   assign rsp_fault_code   = out_err_ff;
   assign rsp_frame_done   = out_done_ff;
   assign rsp_frame_good   = out_good_ff;

endmodule

// File: src/ifs_checker.sv
// Port-level checker for the IPP frame scanner, bound to the top level.
module ifs_checker
   import ifs_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [3:0] rsp_byte_class,
   input logic [4:0] rsp_group_number,
   input logic [3:0] rsp_fault_code,
   input logic       rsp_frame_done,
   input logic       rsp_frame_good
);

   // a good frame end carries no error
   a_good_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_good |-> rsp_frame_done && rsp_fault_code == ERR_NONE)
      else $error("good frame end with error or without done");

   // a failed frame end always names its error
   a_fail_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done && !rsp_frame_good |-> rsp_fault_code != ERR_NONE)
      else $error("frame failed without an error code");

   // an error outside the final byte only shows on ignored bytes
   a_err_ignored: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_done && rsp_fault_code != ERR_NONE
      |-> rsp_byte_class == CL_IGNORED)
      else $error("error code on a non-ignored byte");

   // input backs up only behind a held result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a stalled result");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_byte_class)
      && $stable(rsp_fault_code) && $stable(rsp_group_number))
      else $error("stalled result changed");

endmodule

bind ipp_frame_scanner ifs_checker u_ifs_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_byte_class   (rsp_byte_class),
   .rsp_group_number (rsp_group_number),
   .rsp_fault_code   (rsp_fault_code),
   .rsp_frame_done   (rsp_frame_done),
   .rsp_frame_good   (rsp_frame_good)
);

// File: tb/ipp_frame_scanner_tb.sv
// Self-checking testbench for the IPP frame scanner: frame stimulus, byte predictor, checker.
module ipp_frame_scanner_tb;
   import ifs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Longest quiet stretch: the long receiver hold plus random stall runs, with margin.
   localparam int QUIET_LIMIT = 2000;
   localparam int LONG_HOLD   = 400;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } frame_byte_type;

   typedef struct {
      class_type  cls;
      logic [4:0] grp;
      logic [3:0] err;
      logic       done;
      logic       good;
   } verdict_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_frame_byte = 8'h00;
   logic       req_is_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [3:0] rsp_byte_class;
   logic [4:0] rsp_group_number;
   logic [3:0] rsp_fault_code;
   logic       rsp_frame_done;
   logic       rsp_frame_good;

   ipp_frame_scanner dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_frame_byte   (req_frame_byte),
      .req_is_last      (req_is_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_byte_class   (rsp_byte_class),
      .rsp_group_number (rsp_group_number),
      .rsp_fault_code   (rsp_fault_code),
      .rsp_frame_done   (rsp_frame_done),
      .rsp_frame_good   (rsp_frame_good)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   frame_byte_type bytes_to_send[$];
   verdict_type    verdicts_due[$];
   logic [7:0]  frame_buf[$];
   int          bytes_queued = 0;

   int          send_idle_pct = 18;
   int          recv_idle_pct = 69;
   logic        long_hold_go = 1'b0;
   logic        long_hold_taken = 1'b0;
   int          long_hold_left = 0;

   int          errors = 0;
   int          bytes_sent = 0;
   int          frames_ended = 0;
   int          frames_good = 0;
   logic [15:0] codes_hit = '0;
   int          quiet_cycles = 0;

   frame_byte_type next_byte;
   verdict_type    want;

   // ---------------- scanner predictor ----------------
   phase_type   scan_ph = PH_HEADER;
   logic [15:0] rec_pos = '0;
   logic [15:0] bytes_left = '0;
   logic [4:0]  groups = '0;
   logic [3:0]  held_err = ERR_NONE;
   logic        err_latched = 1'b0;
   verdict_type cur;

   function void clear_frame();
      scan_ph     = PH_HEADER;
      rec_pos     = '0;
      bytes_left  = '0;
      groups      = '0;
      held_err    = ERR_NONE;
      err_latched = 1'b0;
   endfunction

   function void abort_frame(input logic [3:0] code);
      held_err    = code;
      err_latched = 1'b1;
      cur.err     = code;
      cur.done    = 1'b1;
      scan_ph     = PH_IGNORE;
   endfunction

   // Content error kept until the truncation window closes.
   function void defer_error(input logic [3:0] code, input logic [15:0] wait_bytes);
      held_err   = code;
      bytes_left = wait_bytes;
      scan_ph    = PH_WAIT;
   endfunction

   function logic [3:0] cut_code();
      return (rec_pos >= RECORD_MIN - 1) ? ERR_NAME_TRUNC : ERR_RECORD_SHORT;
   endfunction

   function void bump_pos();
      if (rec_pos != 16'hffff) rec_pos++;
   endfunction

   function void tag_byte(input logic [7:0] b, input logic last);
      if (b == END_TAG) begin
         cur.cls = CL_END_TAG;
         if (last) begin
            cur.done = 1'b1;
            cur.good = 1'b1;
         end else begin
            scan_ph = PH_DATA;
         end
      end else if (b <= MAX_DELIM_TAG) begin
         cur.cls = CL_GROUP_TAG;
         if (groups >= MAX_GROUPS) begin
            abort_frame(ERR_GROUPS);
         end else begin
            groups++;
            if (last) abort_frame(ERR_END_AT_DELIM);
            else scan_ph = PH_TAG;
         end
      end else begin
         cur.cls = CL_VALUE_TAG;
         rec_pos = '0;
         if (last) abort_frame(ERR_RECORD_SHORT);
         else if (b[7]) defer_error(ERR_VTAG_NEG, 16'(RECORD_MIN - 1));
         else scan_ph = PH_NL_HI;
      end
   endfunction

   function verdict_type classify_byte(input logic [7:0] b, input logic last);
      cur.cls  = CL_IGNORED;
      cur.err  = ERR_NONE;
      cur.done = 1'b0;
      cur.good = 1'b0;
      case (scan_ph)
         PH_HEADER: begin
            if (rec_pos < HEADER_LEN - 1) begin
               cur.cls = CL_HEADER;
               if (last) begin
                  abort_frame(ERR_SHORT_HEADER);
               end else begin
                  if (held_err == ERR_NONE && b[7]) begin
                     case (rec_pos)
                        16'd0: held_err = ERR_MAJOR_NEG;
                        16'd1: held_err = ERR_MINOR_NEG;
                        16'd2: held_err = ERR_OPID_NEG;
                        16'd4: held_err = ERR_REQID_NEG;
                        default: ;
                     endcase
                  end
                  rec_pos++;
               end
            end else if (held_err != ERR_NONE) begin
               cur.cls = CL_HEADER;
               abort_frame(held_err);
            end else if (b > MAX_DELIM_TAG) begin
               cur.cls = CL_HEADER;
               abort_frame(ERR_DELIM_EXP);
            end else begin
               tag_byte(b, last);
            end
         end
         PH_TAG: tag_byte(b, last);
         PH_NL_HI: begin
            cur.cls = CL_NAME_LEN;
            bump_pos();
            if (last) abort_frame(cut_code());
            else if (b[7]) defer_error(ERR_NLEN_NEG, 16'(RECORD_MIN - 1) - rec_pos);
            else begin
               bytes_left = {b, 8'h00};
               scan_ph    = PH_NL_LO;
            end
         end
         PH_NL_LO: begin
            cur.cls = CL_NAME_LEN;
            bump_pos();
            bytes_left[7:0] = bytes_left[7:0] | b;
            if (last) abort_frame(cut_code());
            else scan_ph = (bytes_left != 0) ? PH_NAME : PH_VL_HI;
         end
         PH_NAME: begin
            cur.cls = CL_NAME;
            bump_pos();
            if (bytes_left != 0) bytes_left--;
            if (last) abort_frame(cut_code());
            else if (bytes_left == 0) scan_ph = PH_VL_HI;
         end
         PH_VL_HI: begin
            cur.cls = CL_VALUE_LEN;
            bump_pos();
            if (last) abort_frame(cut_code());
            else if (b[7]) defer_error(ERR_VLEN_NEG, 16'(LEN_BYTES - 1));
            else begin
               bytes_left = {b, 8'h00};
               scan_ph    = PH_VL_LO;
            end
         end
         PH_VL_LO: begin
            cur.cls = CL_VALUE_LEN;
            bump_pos();
            bytes_left[7:0] = bytes_left[7:0] | b;
            if (last) abort_frame(bytes_left != 0 ? ERR_VALUE_TRUNC : ERR_END_AT_DELIM);
            else scan_ph = (bytes_left != 0) ? PH_VALUE : PH_TAG;
         end
         PH_VALUE: begin
            cur.cls = CL_VALUE;
            if (bytes_left != 0) bytes_left--;
            if (last) abort_frame(bytes_left != 0 ? ERR_VALUE_TRUNC : ERR_END_AT_DELIM);
            else if (bytes_left == 0) scan_ph = PH_TAG;
         end
         PH_DATA: begin
            cur.cls = CL_DATA;
            if (last) begin
               cur.done = 1'b1;
               cur.good = 1'b1;
            end
         end
         PH_WAIT: begin
            if (bytes_left != 0) bytes_left--;
            if (bytes_left == 0) abort_frame(held_err);
            else if (last) abort_frame(ERR_RECORD_SHORT);
         end
         default: cur.err = err_latched ? held_err : ERR_NONE;
      endcase
      cur.grp = groups;
      if (last) clear_frame();
      return cur;
   endfunction

   // ---------------- driver ----------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         clear_frame();
      end else begin
         if (req_valid && !req_stall) begin
            verdicts_due = {verdicts_due, classify_byte(req_frame_byte, req_is_last)};
            bytes_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (bytes_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_byte = bytes_to_send[0];
               bytes_to_send.delete(0);
               req_frame_byte <= next_byte.data;
               req_is_last    <= next_byte.last;
               req_valid      <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------- monitor and checker ----------------
   function void compare_field(input string what, input int exp_v, input int got_v);
      if (exp_v != got_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, got_v);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (verdicts_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected transaction, class %0d error %0d", $time,
                        rsp_byte_class, rsp_fault_code);
            end else begin
               want = verdicts_due[0];
               verdicts_due.delete(0);
               compare_field("byte_class", int'(want.cls), int'(rsp_byte_class));
               compare_field("group_number", int'(want.grp), int'(rsp_group_number));
               compare_field("fault_code", int'(want.err), int'(rsp_fault_code));
               compare_field("frame_done", int'(want.done), int'(rsp_frame_done));
               compare_field("frame_good", int'(want.good), int'(rsp_frame_good));
               if (want.done) begin
                  frames_ended++;
                  if (want.good) frames_good++;
                  if (want.err != ERR_NONE) codes_hit[want.err] = 1'b1;
               end
            end
         end
         if (long_hold_go && !long_hold_taken) begin
            long_hold_taken <= 1'b1;
            long_hold_left  <= LONG_HOLD;
            rsp_stall       <= 1'b1;
         end else if (long_hold_left != 0) begin
            long_hold_left <= long_hold_left - 1;
            rsp_stall      <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // ---------------- watchdog ----------------
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no transaction for %0d cycles, %0d results outstanding", $time,
                  quiet_cycles, verdicts_due.size());
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------- frame building ----------------
   task automatic put(input logic [7:0] b);
      frame_buf = {frame_buf, b};
   endtask

   // Eight header bytes; neg_at picks one byte to get its sign bit.
   task automatic put_header(input int neg_at);
      logic [7:0] b;
      for (int i = 0; i < HEADER_LEN - 1; i++) begin
         b = 8'($urandom_range(0, 127));
         if (i == neg_at || ((i == 3 || i > 4) && $urandom_range(3) == 0)) b[7] = 1'b1;
         put(b);
      end
   endtask

   task automatic put_record(input logic [15:0] name_len, input logic [15:0] value_len);
      put(8'($urandom_range(16, 127)));
      put(name_len[15:8]);
      put(name_len[7:0]);
      repeat (name_len) put(8'($urandom));
      put(value_len[15:8]);
      put(value_len[7:0]);
      repeat (value_len) put(8'($urandom));
   endtask

   // Queue the built frame, cut to keep bytes when keep is in range.
   task automatic send_frame(input int keep);
      int n;
      frame_byte_type fb;
      n = (keep > 0 && keep < frame_buf.size()) ? keep : frame_buf.size();
      for (int i = 0; i < n; i++) begin
         fb.data = frame_buf[i];
         fb.last = (i == n - 1);
         bytes_to_send = {bytes_to_send, fb};
      end
      bytes_queued += n;
      frame_buf.delete();
   endtask

   task automatic build_random_frame();
      int groups_n;
      int keep;
      int mangle;
      if ($urandom_range(11) == 0) begin
         // raw noise, often short frames
         repeat ($urandom_range(1, 12)) put(8'($urandom));
         send_frame(0);
      end else begin
         put_header($urandom_range(7) == 0 ? int'($urandom_range(0, 7)) : -1);
         groups_n = ($urandom_range(19) == 0) ? $urandom_range(15, 18) : $urandom_range(1, 3);
         for (int g = 0; g < groups_n; g++) begin
            put(8'($urandom_range(0, MAX_DELIM_TAG)));
            if (groups_n <= 3)
               repeat ($urandom_range(0, 3))
                  put_record(16'($urandom_range(0, 5)), 16'($urandom_range(0, 6)));
         end
         put(8'(END_TAG));
         repeat ($urandom_range(0, 4)) put(8'($urandom));
         keep = 0;
         mangle = $urandom_range(9);
         if (mangle >= 8) frame_buf[$urandom_range(0, frame_buf.size() - 1)] = 8'($urandom);
         if (mangle == 6 || mangle == 7 || mangle == 9)
            keep = $urandom_range(1, frame_buf.size());
         send_frame(keep);
      end
   endtask

   task automatic queue_random_bytes(input int count);
      int goal;
      goal = bytes_queued + count;
      while (bytes_queued < goal) build_random_frame();
   endtask

   task automatic wait_drained();
      while (bytes_to_send.size() != 0 || req_valid || verdicts_due.size() != 0)
         @(negedge clock);
   endtask

   // ---------------- test sequence ----------------
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // shortest good frame, short header, truncation over a held sign error
      put_header(-1); put(8'(END_TAG)); send_frame(0);
      put_header(-1); send_frame(3);
      put_header(0); send_frame(5);
      // each checked header field negative
      for (int k = 0; k < 5; k++) begin
         if (k != 3) begin
            put_header(k); put(8'h01); put(8'h20); send_frame(0);
         end
      end
      // sign bits in header bytes that are not checked
      put(8'h01); put(8'h01); put(8'h00); put(8'hff);
      put(8'h00); put(8'hff); put(8'hff); put(8'hff);
      put(8'h01); put_record(0, 0); put(8'(END_TAG)); put(8'hff); put(8'h00); send_frame(0);
      // delimiter expected
      put_header(-1); put(8'h10); send_frame(0);
      put_header(-1); put(8'hff); put(8'h01); send_frame(0);
      // group limit reached, then exceeded
      put_header(-1); repeat (MAX_GROUPS) put(8'h02); put(8'(END_TAG)); send_frame(0);
      put_header(-1); repeat (MAX_GROUPS + 1) put(8'h0f); put(8'(END_TAG)); send_frame(0);
      // frame ends on a group tag, on a value tag
      put_header(-1); put(8'h00); send_frame(0);
      put_header(-1); put(8'h01); put(8'h7f); send_frame(0);
      // negative value tag: held, then cut inside its window
      put_header(-1); put(8'h01); put(8'h80); repeat (4) put(8'h00); put(8'(END_TAG));
      send_frame(0);
      put_header(-1); put(8'h01); put(8'hc5); put(8'h00); send_frame(0);
      // negative name length
      put_header(-1); put(8'h01); put(8'h41); put(8'h80); repeat (3) put(8'h00); send_frame(0);
      // cut in name length low byte, first name byte, second name byte
      for (int k = 12; k <= 14; k++) begin
         put_header(-1); put(8'h01); put_record(6, 2); send_frame(k);
      end
      // negative value length
      put_header(-1); put(8'h01); put(8'h44); put(8'h00); put(8'h00);
      put(8'h80); put(8'h00); put(8'(END_TAG)); send_frame(0);
      // frame ends right after a value, inside a value, on a zero value length
      put_header(-1); put(8'h01); put_record(1, 4); send_frame(0);
      put_header(-1); put(8'h01); put_record(1, 4); send_frame(frame_buf.size() - 2);
      put_header(-1); put(8'h01); put_record(0, 0); send_frame(0);
      // value length above one byte, cut inside the value
      put_header(-1); put(8'h01); put_record(3, 300); send_frame(40);
      // second group, data after the end tag
      put_header(-1); put(8'h01); put_record(3, 20); put(8'h04); put_record(0, 1);
      put(8'(END_TAG)); repeat (3) put(8'($urandom)); send_frame(0);
      put_header(-1); put(8'(END_TAG)); put(8'h80); put(8'h03); send_frame(0);
      put(8'h00); send_frame(0);
      wait_drained();

      queue_random_bytes(65);
      wait_drained();

      send_idle_pct = 69;
      recv_idle_pct = 18;
      queue_random_bytes(65);
      wait_drained();

      // no idling; a long receiver hold first fills the block
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random_bytes(65);
      long_hold_go = 1'b1;
      wait_drained();

      repeat (12) @(negedge clock);
      $display("Scanned %0d bytes; %0d frames finished, %0d of them good", bytes_sent,
               frames_ended, frames_good);
      $display("Distinct error codes reported: %0d of 14", $countones(codes_hit));
      if (errors == 0 && verdicts_due.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: ipp_frame_scanner.f
src/ifs_pkg.sv
src/ipp_frame_scanner.sv
src/ifs_checker.sv
tb/ipp_frame_scanner_tb.sv
